// File: hdl/ecalu_pkg.sv
// shared types and operation codes for the 8-bit cpu alu
// no dependencies; used by ecalu_core and the top level
package ecalu_pkg;

  localparam int unsigned OpW    = 5;
  localparam int unsigned WordW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FlagW  = 4;
  localparam int unsigned BitIdxW = 3;

  // flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [OpW-1:0] {
    OP_INC   = 5'd0,
    OP_DEC   = 5'd1,
    OP_ADD   = 5'd2,
    OP_ADC   = 5'd3,
    OP_SUB   = 5'd4,
    OP_SBC   = 5'd5,
    OP_AND   = 5'd6,
    OP_XOR   = 5'd7,
    OP_OR    = 5'd8,
    OP_CP    = 5'd9,
    OP_ADD16 = 5'd10,
    OP_ADDSP = 5'd11,
    OP_RLCA  = 5'd12,
    OP_RRCA  = 5'd13,
    OP_RLA   = 5'd14,
    OP_RRA   = 5'd15,
    OP_DAA   = 5'd16,
    OP_CPL   = 5'd17,
    OP_SCF   = 5'd18,
    OP_CCF   = 5'd19,
    OP_RLC   = 5'd20,
    OP_RRC   = 5'd21,
    OP_RL    = 5'd22,
    OP_RR    = 5'd23,
    OP_SLA   = 5'd24,
    OP_SRA   = 5'd25,
    OP_SRL   = 5'd26,
    OP_SWAP  = 5'd27,
    OP_BIT   = 5'd28
  } alu_op_t;

  typedef struct packed {
    logic [OpW-1:0]        mode;
    logic [WordW-1:0]      first_operand;
    logic [FlagW-1:0]      flags_in;
    logic [WordW-1:0]      second_operand;
    logic signed [ByteW-1:0] offset;
    logic [BitIdxW-1:0]    bit_index;
  } ecalu_req_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic [FlagW-1:0] flags_out;
  } ecalu_res_t;

endpackage

// File: hdl/ecalu_core.sv
// combinational datapath of the alu: one request in, value and flags out
// depends on ecalu_pkg
module ecalu_core (
  input  ecalu_pkg::ecalu_req_t req,
  output ecalu_pkg::ecalu_res_t res
);
  import ecalu_pkg::*;

  logic [ByteW-1:0] a;
  logic [ByteW-1:0] v;
  logic             cin;
  logic             fz;
  logic             fn;
  logic             fh;
  alu_op_t          op;

  logic             add_c;
  logic [ByteW:0]   add_sum;
  logic [4:0]       add_half;
  logic             sub_c;
  logic [ByteW:0]   sub_diff;
  logic [4:0]       sub_half;
  logic [WordW:0]   w_sum;
  logic [12:0]      w_half;
  logic [WordW-1:0] sp_sum;
  logic [4:0]       sp_half;
  logic [ByteW:0]   sp_low;
  logic             daa_lo;
  logic [ByteW:0]   daa_t1;
  logic             daa_hi;
  logic [ByteW:0]   daa_t2;
  logic [ByteW-1:0] daa_s1;
  logic [ByteW-1:0] daa_s2;
  logic [ByteW-1:0] inc_v;
  logic [ByteW-1:0] dec_v;

  assign op  = alu_op_t'(req.mode);
  assign a   = req.first_operand[ByteW-1:0];
  assign v   = req.second_operand[ByteW-1:0];
  assign cin = req.flags_in[FlagC];
  assign fz  = req.flags_in[FlagZ];
  assign fn  = req.flags_in[FlagN];
  assign fh  = req.flags_in[FlagH];

  assign inc_v = v + 8'd1;
  assign dec_v = v - 8'd1;

  assign add_c    = (op == OP_ADC) ? cin : 1'b0;
  assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, add_c};
  assign add_half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, add_c};

  // borrow shows up as the top bit of the widened difference
  assign sub_c    = (op == OP_SBC) ? cin : 1'b0;
  assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, sub_c};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, sub_c};

  assign w_sum  = {1'b0, req.first_operand} + {1'b0, req.second_operand};
  assign w_half = {1'b0, req.first_operand[11:0]} + {1'b0, req.second_operand[11:0]};

  assign sp_sum  = req.first_operand + {{8{req.offset[7]}}, req.offset};
  assign sp_half = {1'b0, req.first_operand[3:0]} + {1'b0, req.offset[3:0]};
  assign sp_low  = {1'b0, req.first_operand[7:0]} + {1'b0, req.offset};

  // decimal adjust, addition side
  assign daa_lo = fh || (a[3:0] > 4'd9);
  assign daa_t1 = {1'b0, a} + (daa_lo ? 9'h006 : 9'h000);
  assign daa_hi = cin || (daa_t1 > 9'h09F);
  assign daa_t2 = daa_t1 + (daa_hi ? 9'h060 : 9'h000);
  // decimal adjust, subtraction side
  assign daa_s1 = fh ? (a - 8'h06) : a;
  assign daa_s2 = cin ? (daa_s1 - 8'h60) : daa_s1;

  always_comb begin
    logic [ByteW-1:0] r8;
    logic [WordW-1:0] r16;
    logic [FlagW-1:0] nf;
    logic             wide;
    r8   = a;
    r16  = '0;
    nf   = req.flags_in;
    wide = 1'b0;
    unique case (op)
      OP_INC: begin
        r8 = inc_v;
        nf = {inc_v == 8'h00, 1'b0, v[3:0] == 4'hF, cin};
      end
      OP_DEC: begin
        r8 = dec_v;
        nf = {dec_v == 8'h00, 1'b1, v[3:0] == 4'h0, cin};
      end
      OP_ADD, OP_ADC: begin
        r8 = add_sum[7:0];
        nf = {add_sum[7:0] == 8'h00, 1'b0, add_half[4], add_sum[8]};
      end
      OP_SUB, OP_SBC: begin
        r8 = sub_diff[7:0];
        nf = {sub_diff[7:0] == 8'h00, 1'b1, sub_half[4], sub_diff[8]};
      end
      OP_CP: begin
        nf = {sub_diff[7:0] == 8'h00, 1'b1, sub_half[4], sub_diff[8]};
      end
      OP_AND: begin
        r8 = a & v;
        nf = {(a & v) == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r8 = a ^ v;
        nf = {(a ^ v) == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      OP_OR: begin
        r8 = a | v;
        nf = {(a | v) == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      OP_ADD16: begin
        wide = 1'b1;
        r16  = w_sum[WordW-1:0];
        nf   = {fz, 1'b0, w_half[12], w_sum[WordW]};
      end
      OP_ADDSP: begin
        wide = 1'b1;
        r16  = sp_sum;
        nf   = {1'b0, 1'b0, sp_half[4], sp_low[8]};
      end
      OP_RLCA: begin
        r8 = {a[6:0], a[7]};
        nf = {1'b0, 1'b0, 1'b0, a[7]};
      end
      OP_RRCA: begin
        r8 = {a[0], a[7:1]};
        nf = {1'b0, 1'b0, 1'b0, a[0]};
      end
      OP_RLA: begin
        r8 = {a[6:0], cin};
        nf = {1'b0, 1'b0, 1'b0, a[7]};
      end
      OP_RRA: begin
        r8 = {cin, a[7:1]};
        nf = {1'b0, 1'b0, 1'b0, a[0]};
      end
      OP_DAA: begin
        if (fn) begin
          r8 = daa_s2;
          nf = {daa_s2 == 8'h00, 1'b1, 1'b0, cin};
        end else begin
          r8 = daa_t2[7:0];
          nf = {daa_t2[7:0] == 8'h00, 1'b0, 1'b0, cin | daa_t2[8]};
        end
      end
      OP_CPL: begin
        r8 = ~a;
        nf = {fz, 1'b1, 1'b1, cin};
      end
      OP_SCF: begin
        nf = {fz, 1'b0, 1'b0, 1'b1};
      end
      OP_CCF: begin
        nf = {fz, 1'b0, 1'b0, ~cin};
      end
      OP_RLC: begin
        r8 = {v[6:0], v[7]};
        nf = {{v[6:0], v[7]} == 8'h00, 1'b0, 1'b0, v[7]};
      end
      OP_RRC: begin
        r8 = {v[0], v[7:1]};
        nf = {{v[0], v[7:1]} == 8'h00, 1'b0, 1'b0, v[0]};
      end
      OP_RL: begin
        r8 = {v[6:0], cin};
        nf = {{v[6:0], cin} == 8'h00, 1'b0, 1'b0, v[7]};
      end
      OP_RR: begin
        r8 = {cin, v[7:1]};
        nf = {{cin, v[7:1]} == 8'h00, 1'b0, 1'b0, v[0]};
      end
      OP_SLA: begin
        r8 = {v[6:0], 1'b0};
        nf = {v[6:0] == 7'h00, 1'b0, 1'b0, v[7]};
      end
      OP_SRA: begin
        r8 = {v[7], v[7:1]};
        nf = {v[7:1] == 7'h00, 1'b0, 1'b0, v[0]};
      end
      OP_SRL: begin
        r8 = {1'b0, v[7:1]};
        nf = {v[7:1] == 7'h00, 1'b0, 1'b0, v[0]};
      end
      OP_SWAP: begin
        r8 = {v[3:0], v[7:4]};
        nf = {v == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      OP_BIT: begin
        r8 = v;
        nf = {~v[req.bit_index], 1'b0, 1'b1, cin};
      end
      default: begin
        // unused codes pass the accumulator and flags through
        r8 = a;
        nf = req.flags_in;
      end
    endcase
    res.result    = wide ? r16 : {8'h00, r8};
    res.flags_out = nf;
  end

endmodule

// File: hdl/eight_bit_cpu_alu_with_flags.sv
// top level of the 8-bit cpu alu: input register, datapath, result register
// depends on ecalu_pkg and ecalu_core
//
// Two-stage registered ALU for an 8-bit CPU core. A request carries an
// operation code, the accumulator (or first word / stack pointer), the old
// Z N H C flags, a second operand, a signed offset and a bit index; the
// result carries the new value and the new flags. One request is taken
// every clock cycle while in_ready is high. An accepted request is held in
// the input register, then the result register holds its result on the
// output until it is taken, with the whole operation done by the datapath
// in between. Each stage moves forward whenever the stage after it is
// empty or being emptied, so a stall on the output backs up through the
// two stages before in_ready drops. No configuration and no state beyond
// the pipeline; reset only empties the stages.
module eight_bit_cpu_alu_with_flags (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [ecalu_pkg::OpW-1:0]               in_mode,
  input  logic [ecalu_pkg::WordW-1:0]             in_first_operand,
  input  logic [ecalu_pkg::FlagW-1:0]             in_flags_in,
  input  logic [ecalu_pkg::WordW-1:0]             in_second_operand,
  input  logic signed [ecalu_pkg::ByteW-1:0]      in_offset,
  input  logic [ecalu_pkg::BitIdxW-1:0]           in_bit_index,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [ecalu_pkg::WordW-1:0]             out_result,
  output logic [ecalu_pkg::FlagW-1:0]             out_flags_out
);
  import ecalu_pkg::*;

  // input stage
  logic       req_valid_r;
  logic       req_valid_nxt;
  ecalu_req_t req_r;
  // result stage
  logic       res_valid_r;
  logic       res_valid_nxt;
  ecalu_res_t res_r;
  ecalu_res_t res_nxt;

  logic in_take;    // request accepted into the input stage
  logic req_move;   // input stage hands its request to the result stage
  logic res_free;   // result stage can take a new value this cycle

  assign res_free = !res_valid_r || out_ready;
  assign req_move = req_valid_r && res_free;
  assign in_ready = !req_valid_r || res_free;
  assign in_take  = in_valid && in_ready;

  // stage occupancy: filled by a take, kept while blocked downstream
  assign req_valid_nxt = in_take || (req_valid_r && !res_free);
  assign res_valid_nxt = req_move || (res_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // payload registers load only on a take or a move, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.mode           <= in_mode;
      req_r.first_operand  <= in_first_operand;
      req_r.flags_in       <= in_flags_in;
      req_r.second_operand <= in_second_operand;
      req_r.offset         <= in_offset;
      req_r.bit_index      <= in_bit_index;
    end
  end

  ecalu_core u_core (
    .req (req_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (req_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = res_valid_r;
  assign out_result    = res_r.result;
  assign out_flags_out = res_r.flags_out;

endmodule

// File: hdl/ecalu_checker.sv
// port-level checks for the 8-bit cpu alu, bound to the top level
// depends on eight_bit_cpu_alu_with_flags port names only
module ecalu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_result,
  input logic [3:0]  out_flags_out
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // with the result stage empty the block must take a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused while result stage empty");

  // an accepted request reaches the output through both registers when not stalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("request lost or late in pipeline");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) &&
                                $stable(out_flags_out))
    else $error("stalled result changed");

endmodule

bind eight_bit_cpu_alu_with_flags ecalu_checker u_ecalu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_result    (out_result),
  .out_flags_out (out_flags_out)
);

// File: sim/testbench.sv
// self-checking testbench for eight_bit_cpu_alu_with_flags
// needs ecalu_pkg and the alu rtl; drives directed then random requests and
// checks every result against a typed-in answer or a local model of the alu
`timescale 1ns / 1ps

module testbench;
  import ecalu_pkg::*;

  // spare operation codes, the alu must pass A and the flags through
  localparam logic [OpW-1:0] OpSpareTop = 5'd31;

  localparam int unsigned RandomRequests = 2000;
  localparam int unsigned DrainCycles    = 16;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned PrintLimit     = 20;

  // one row of stimulus: the request plus an optional typed-in answer
  typedef struct {
    ecalu_req_t req;
    bit         typed;
    ecalu_res_t want;
  } stim_row_t;

  // one result still owed by the alu, with the request that caused it
  typedef struct {
    ecalu_req_t req;
    ecalu_res_t want;
  } owed_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [OpW-1:0] in_mode;
  logic [WordW-1:0] in_first_operand;
  logic [FlagW-1:0] in_flags_in;
  logic [WordW-1:0] in_second_operand;
  logic signed [ByteW-1:0] in_offset;
  logic [BitIdxW-1:0] in_bit_index;
  logic out_valid;
  logic out_ready;
  logic [WordW-1:0] out_result;
  logic [FlagW-1:0] out_flags_out;

  // typed-in answer that travels with the request now on the input port
  bit cur_typed;
  ecalu_res_t cur_want;

  stim_row_t stim_rows[$];
  owed_result_t owed_results[$];
  int unsigned mismatches;
  int unsigned requests_taken;
  int unsigned results_checked;
  int unsigned cycle_count;
  bit [31:0] ops_seen;

  eight_bit_cpu_alu_with_flags u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_first_operand  (in_first_operand),
    .in_flags_in       (in_flags_in),
    .in_second_operand (in_second_operand),
    .in_offset         (in_offset),
    .in_bit_index      (in_bit_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result        (out_result),
    .out_flags_out     (out_flags_out)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // flags are packed z n h c from bit 3 down to bit 0
  function automatic logic [FlagW-1:0] pack_flags(logic z, logic n, logic h, logic c);
    return {z, n, h, c};
  endfunction

  // what the alu must return for one request
  function automatic ecalu_res_t alu_outcome(ecalu_req_t rq);
    logic [7:0] a;
    logic [7:0] v;
    logic [7:0] r8;
    logic [8:0] s9;
    logic [4:0] h5;
    logic [16:0] s17;
    logic [12:0] h13;
    logic [8:0] adj;
    logic cin;
    logic cc;
    logic cy;
    logic [FlagW-1:0] f;
    ecalu_res_t o;
    a   = rq.first_operand[7:0];
    v   = rq.second_operand[7:0];
    f   = rq.flags_in;
    cin = f[FlagC];
    // spare codes fall through with A and the old flags
    o.result    = {8'h00, a};
    o.flags_out = f;
    case (rq.mode)
      OP_INC: begin
        r8 = v + 8'd1;
        o.result = {8'h00, r8};
        o.flags_out = pack_flags(r8 == 8'h00, 1'b0, v[3:0] == 4'hF, cin);
      end
      OP_DEC: begin
        r8 = v - 8'd1;
        o.result = {8'h00, r8};
        o.flags_out = pack_flags(r8 == 8'h00, 1'b1, v[3:0] == 4'h0, cin);
      end
      OP_ADD, OP_ADC: begin
        cc = (rq.mode == OP_ADC) ? cin : 1'b0;
        s9 = {1'b0, a} + {1'b0, v} + cc;
        h5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + cc;
        o.result = {8'h00, s9[7:0]};
        o.flags_out = pack_flags(s9[7:0] == 8'h00, 1'b0, h5[4], s9[8]);
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // borrows show up as the top bit of the widened difference
        cc = (rq.mode == OP_SBC) ? cin : 1'b0;
        s9 = {1'b0, a} - {1'b0, v} - cc;
        h5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - cc;
        o.result = (rq.mode == OP_CP) ? {8'h00, a} : {8'h00, s9[7:0]};
        o.flags_out = pack_flags(s9[7:0] == 8'h00, 1'b1, h5[4], s9[8]);
      end
      OP_AND: begin
        r8 = a & v;
        o.result = {8'h00, r8};
        o.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      OP_XOR, OP_OR: begin
        r8 = (rq.mode == OP_XOR) ? (a ^ v) : (a | v);
        o.result = {8'h00, r8};
        o.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_ADD16: begin
        s17 = {1'b0, rq.first_operand} + {1'b0, rq.second_operand};
        h13 = {1'b0, rq.first_operand[11:0]} + {1'b0, rq.second_operand[11:0]};
        o.result = s17[15:0];
        o.flags_out = pack_flags(f[FlagZ], 1'b0, h13[12], s17[16]);
      end
      OP_ADDSP: begin
        // sum is signed, carries come from the unsigned low byte
        o.result = rq.first_operand + {{8{rq.offset[7]}}, rq.offset};
        h5 = {1'b0, rq.first_operand[3:0]} + {1'b0, rq.offset[3:0]};
        s9 = {1'b0, rq.first_operand[7:0]} + {1'b0, rq.offset};
        o.flags_out = pack_flags(1'b0, 1'b0, h5[4], s9[8]);
      end
      OP_RLCA: begin
        o.result = {8'h00, a[6:0], a[7]};
        o.flags_out = pack_flags(1'b0, 1'b0, 1'b0, a[7]);
      end
      OP_RRCA: begin
        o.result = {8'h00, a[0], a[7:1]};
        o.flags_out = pack_flags(1'b0, 1'b0, 1'b0, a[0]);
      end
      OP_RLA: begin
        o.result = {8'h00, a[6:0], cin};
        o.flags_out = pack_flags(1'b0, 1'b0, 1'b0, a[7]);
      end
      OP_RRA: begin
        o.result = {8'h00, cin, a[7:1]};
        o.flags_out = pack_flags(1'b0, 1'b0, 1'b0, a[0]);
      end
      OP_DAA: begin
        adj = {1'b0, a};
        cy  = cin;
        if (!f[FlagN]) begin
          if (f[FlagH] || adj[3:0] > 4'd9) adj = adj + 9'h006;
          if (cin || adj > 9'h09F) adj = adj + 9'h060;
          if (adj[8]) cy = 1'b1;
        end else begin
          if (f[FlagH]) adj = {1'b0, adj[7:0] - 8'h06};
          if (cin) adj = adj - 9'h060;
        end
        o.result = {8'h00, adj[7:0]};
        o.flags_out = pack_flags(adj[7:0] == 8'h00, f[FlagN], 1'b0, cy);
      end
      OP_CPL: begin
        o.result = {8'h00, ~a};
        o.flags_out = pack_flags(f[FlagZ], 1'b1, 1'b1, cin);
      end
      OP_SCF: o.flags_out = pack_flags(f[FlagZ], 1'b0, 1'b0, 1'b1);
      OP_CCF: o.flags_out = pack_flags(f[FlagZ], 1'b0, 1'b0, ~cin);
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
        case (rq.mode)
          OP_RLC:  begin r8 = {v[6:0], v[7]}; cy = v[7]; end
          OP_RRC:  begin r8 = {v[0], v[7:1]}; cy = v[0]; end
          OP_RL:   begin r8 = {v[6:0], cin};  cy = v[7]; end
          OP_RR:   begin r8 = {cin, v[7:1]};  cy = v[0]; end
          OP_SLA:  begin r8 = {v[6:0], 1'b0}; cy = v[7]; end
          OP_SRA:  begin r8 = {v[7], v[7:1]}; cy = v[0]; end
          default: begin r8 = {1'b0, v[7:1]}; cy = v[0]; end
        endcase
        o.result = {8'h00, r8};
        o.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b0, cy);
      end
      OP_SWAP: begin
        r8 = {v[3:0], v[7:4]};
        o.result = {8'h00, r8};
        o.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_BIT: begin
        o.result = {8'h00, v};
        o.flags_out = pack_flags(~v[rq.bit_index], 1'b0, 1'b1, cin);
      end
      default: ;
    endcase
    return o;
  endfunction

  // bytes and words lean toward carry and nibble boundaries
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h0F;
      3: return 8'h10;
      4: return 8'h7F;
      5: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0FFF;
      3: return 16'h1000;
      4: return 16'h8000;
      5: return {8'($urandom), pick_byte()};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_row(input logic [OpW-1:0] mode, input logic [15:0] w1,
                         input logic [3:0] fl, input logic [15:0] w2,
                         input logic [7:0] off, input logic [2:0] idx,
                         input bit typed, input logic [15:0] res,
                         input logic [3:0] res_fl);
    stim_row_t row;
    row.req.mode           = mode;
    row.req.first_operand  = w1;
    row.req.flags_in       = fl;
    row.req.second_operand = w2;
    row.req.offset         = off;
    row.req.bit_index      = idx;
    row.typed              = typed;
    row.want.result        = res;
    row.want.flags_out     = res_fl;
    stim_rows.push_back(row);
  endtask

  // put one request on the port and hold it until the alu takes it;
  // called and returns at a falling edge
  task automatic send_request(input stim_row_t row);
    in_mode           <= row.req.mode;
    in_first_operand  <= row.req.first_operand;
    in_flags_in       <= row.req.flags_in;
    in_second_operand <= row.req.second_operand;
    in_offset         <= row.req.offset;
    in_bit_index      <= row.req.bit_index;
    cur_typed         <= row.typed;
    cur_want          <= row.want;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input ecalu_req_t rq,
                                 input int unsigned got, input int unsigned want);
    if (mismatches < PrintLimit)
      $display("%0t mismatch %s: mode %0d a/w1 %h v/w2 %h f %h off %h bit %0d got %h want %h",
               $realtime, what, rq.mode, rq.first_operand, rq.second_operand, rq.flags_in,
               rq.offset, rq.bit_index, got, want);
    mismatches++;
  endtask

  // scoreboard: record each taken request, check each delivered result
  always @(posedge clk) begin : score
    ecalu_req_t seen;
    owed_result_t owed;
    if (rst_n) begin
      // push before pop so a same-edge request and result stay in order
      if (in_valid && in_ready) begin
        seen.mode           = in_mode;
        seen.first_operand  = in_first_operand;
        seen.flags_in       = in_flags_in;
        seen.second_operand = in_second_operand;
        seen.offset         = in_offset;
        seen.bit_index      = in_bit_index;
        owed.req  = seen;
        owed.want = cur_typed ? cur_want : alu_outcome(seen);
        owed_results.push_back(owed);
        ops_seen[in_mode] = 1'b1;
        requests_taken++;
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with no request", '0, out_result, 0);
        end else begin
          owed = owed_results.pop_front();
          if (out_result !== owed.want.result)
            report_mismatch("result", owed.req, out_result, owed.want.result);
          if (out_flags_out !== owed.want.flags_out)
            report_mismatch("flags", owed.req, out_flags_out, owed.want.flags_out);
          results_checked++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, owed_results.size());
      $display("[eight_bit_cpu_alu_with_flags] ERROR");
      $finish;
    end
  end

  // receiver: back-pressure follows a 7-bit rotating pattern that is swapped
  // now and then; a quarter of the patterns never stall
  initial begin : receiver
    logic [6:0] stall_pattern;
    int unsigned pattern_left;
    out_ready     = 1'b0;
    stall_pattern = 7'h7F;
    pattern_left  = 0;
    forever begin
      @(negedge clk);
      if (pattern_left == 0) begin
        pattern_left  = $urandom_range(50, 300);
        stall_pattern = ($urandom_range(0, 3) == 0) ? 7'h7F : (7'($urandom) | 7'h01);
      end
      pattern_left--;
      stall_pattern = {stall_pattern[5:0], stall_pattern[6]};
      out_ready <= stall_pattern[0];
    end
  end

  // sender: builds the whole stimulus list, then walks it in bursts
  initial begin : sender
    ecalu_req_t pre_rq;
    ecalu_res_t pre_res;
    logic [OpW-1:0] mode;
    int unsigned burst_left;
    int unsigned gap;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_mode           = '0;
    in_first_operand  = '0;
    in_flags_in       = '0;
    in_second_operand = '0;
    in_offset         = '0;
    in_bit_index      = '0;
    cur_typed         = 1'b0;
    cur_want          = '0;
    mismatches        = 0;
    requests_taken    = 0;
    results_checked   = 0;
    cycle_count       = 0;
    ops_seen          = '0;

    // directed rows: mode, a/w1, flags, v/w2, offset, bit, typed, result, flags
    // answers are typed in where they are plain; the rest go to the model
    add_row(OP_INC,   16'h0000, 4'h1, 16'h00FF, 8'h00, 3'd0, 1, 16'h0000, 4'hB);
    add_row(OP_DEC,   16'h0000, 4'h0, 16'h0000, 8'h00, 3'd0, 1, 16'h00FF, 4'h6);
    add_row(OP_ADD,   16'h12FF, 4'h0, 16'hAB01, 8'h00, 3'd0, 1, 16'h0000, 4'hB);
    add_row(OP_ADC,   16'h00FF, 4'h1, 16'h00FF, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_SUB,   16'h0000, 4'h0, 16'h0001, 8'h00, 3'd0, 1, 16'h00FF, 4'h7);
    add_row(OP_SBC,   16'hFF00, 4'hF, 16'h00FF, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_AND,   16'h00F0, 4'h0, 16'h000F, 8'h00, 3'd0, 1, 16'h0000, 4'hA);
    add_row(OP_XOR,   16'h00FF, 4'h0, 16'h00FF, 8'h00, 3'd0, 1, 16'h0000, 4'h8);
    add_row(OP_OR,    16'h0000, 4'hF, 16'h0000, 8'h00, 3'd0, 1, 16'h0000, 4'h8);
    // compare keeps A in the result
    add_row(OP_CP,    16'h003C, 4'h0, 16'h003C, 8'h00, 3'd0, 1, 16'h003C, 4'hC);
    // 16-bit add keeps Z from the old flags
    add_row(OP_ADD16, 16'hFFFF, 4'h8, 16'h0001, 8'h00, 3'd0, 1, 16'h0000, 4'hB);
    // stack pointer plus the most negative and most positive offsets
    add_row(OP_ADDSP, 16'hFFFF, 4'hF, 16'h0000, 8'h80, 3'd0, 0, '0, '0);
    add_row(OP_ADDSP, 16'h00F1, 4'h0, 16'hFFFF, 8'h7F, 3'd0, 0, '0, '0);
    add_row(OP_RLCA,  16'h0080, 4'h0, 16'h0000, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_RRCA,  16'h0001, 4'hF, 16'h0000, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_RLA,   16'h0080, 4'h1, 16'h0000, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_RRA,   16'h0001, 4'h0, 16'h0000, 8'h00, 3'd0, 0, '0, '0);
    // decimal adjust after 99 + 01, then after a subtract with both borrows
    add_row(OP_DAA,   16'h009A, 4'h0, 16'h0000, 8'h00, 3'd0, 1, 16'h0000, 4'h9);
    add_row(OP_DAA,   16'h00FF, 4'h7, 16'h0000, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_CPL,   16'h0000, 4'h0, 16'h0000, 8'h00, 3'd0, 1, 16'h00FF, 4'h6);
    add_row(OP_SCF,   16'h0055, 4'hF, 16'h0000, 8'h00, 3'd0, 1, 16'h0055, 4'h9);
    add_row(OP_CCF,   16'h00AA, 4'hF, 16'h0000, 8'h00, 3'd0, 1, 16'h00AA, 4'h8);
    add_row(OP_RLC,   16'h0000, 4'h0, 16'h0080, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_RRC,   16'h0000, 4'h0, 16'h0001, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_RL,    16'h0000, 4'h0, 16'h0080, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_RR,    16'h0000, 4'h1, 16'h0001, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_SLA,   16'h0000, 4'hF, 16'h00FF, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_SRA,   16'h0000, 4'h0, 16'h0080, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_SRL,   16'h0000, 4'h0, 16'h0001, 8'h00, 3'd0, 0, '0, '0);
    add_row(OP_SWAP,  16'h0000, 4'h0, 16'h00F0, 8'h00, 3'd0, 0, '0, '0);
    // bit test on the top bit, result passes the byte through
    add_row(OP_BIT,   16'h0000, 4'h0, 16'h007F, 8'h00, 3'd7, 1, 16'h007F, 4'hA);
    // spare code: A and flags pass through untouched
    add_row(OpSpareTop, 16'hABCD, 4'h5, 16'h1234, 8'h00, 3'd0, 1, 16'h00CD, 4'h5);

    // random part; about one row in eight is a decimal adjust fed by a real
    // bcd add or subtract so the correction paths all get exercised
    for (int i = 0; i < RandomRequests; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        pre_rq.mode           = OP_ADD + 5'($urandom_range(0, 3));
        pre_rq.first_operand  = {8'($urandom), 4'($urandom_range(0, 9)),
                                 4'($urandom_range(0, 9))};
        pre_rq.second_operand = {8'($urandom), 4'($urandom_range(0, 9)),
                                 4'($urandom_range(0, 9))};
        pre_rq.flags_in       = 4'($urandom);
        pre_rq.offset         = '0;
        pre_rq.bit_index      = '0;
        pre_res = alu_outcome(pre_rq);
        add_row(OP_DAA, {pre_rq.first_operand[15:8], pre_res.result[7:0]}, pre_res.flags_out,
                pick_word(), pick_byte(), 3'($urandom), 0, '0, '0);
      end else begin
        mode = 5'($urandom_range(0, 31));
        add_row(mode, pick_word(), 4'($urandom), pick_word(), pick_byte(), 3'($urandom),
                0, '0, '0);
      end
    end

    // hold reset, then release it away from the sampling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bursts of back-to-back requests with idle gaps between them;
    // a quarter of the bursts follow the previous one with no gap at all
    burst_left = 0;
    foreach (stim_rows[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      send_request(stim_rows[i]);
      burst_left--;
    end
    in_valid <= 1'b0;

    // let the pipeline drain, then watch a little longer for stray results
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d requests using %0d of the 32 operation codes",
             requests_taken, $countones(ops_seen));
    $display("compared %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("[eight_bit_cpu_alu_with_flags] OK");
    end else begin
      $display("[eight_bit_cpu_alu_with_flags] ERROR");
    end
    $finish;
  end

endmodule
